[design/mpoc_pkg.sv]
package mpoc_pkg;

  localparam int BYTE_W  = 8;
  localparam int ALPHA   = 256;
  localparam int KIND_W  = 3;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 4;
  localparam int OCC_W   = 32;
  localparam int SCORE_W = 36;
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  localparam logic [KIND_W-1:0] K_LOAD  = 3'd0;
  localparam logic [KIND_W-1:0] K_BUILD = 3'd1;
  localparam logic [KIND_W-1:0] K_TEXT  = 3'd2;
  localparam logic [KIND_W-1:0] K_EOD   = 3'd3;
  localparam logic [KIND_W-1:0] K_CLEAR = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVF       = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd2;

  localparam logic REG_FOLD_CASE = 1'b0;
  localparam logic REG_SKIP_HIGH = 1'b1;

  // controller states, also the datapath command codes
  localparam int OP_W = 5;
  localparam logic [OP_W-1:0] S_CLEAR  = 5'd0;
  localparam logic [OP_W-1:0] S_IDLE   = 5'd1;
  localparam logic [OP_W-1:0] S_LD_RD  = 5'd2;
  localparam logic [OP_W-1:0] S_LD_EV  = 5'd3;
  localparam logic [OP_W-1:0] S_LD_MR  = 5'd4;
  localparam logic [OP_W-1:0] S_LD_MW  = 5'd5;
  localparam logic [OP_W-1:0] S_TX_RD  = 5'd6;
  localparam logic [OP_W-1:0] S_TX_MR  = 5'd7;
  localparam logic [OP_W-1:0] S_TX_CNT = 5'd8;
  localparam logic [OP_W-1:0] S_B_R0   = 5'd9;
  localparam logic [OP_W-1:0] S_B_R1   = 5'd10;
  localparam logic [OP_W-1:0] S_B_DEQ  = 5'd11;
  localparam logic [OP_W-1:0] S_B_S    = 5'd12;
  localparam logic [OP_W-1:0] S_B_F    = 5'd13;
  localparam logic [OP_W-1:0] S_B_C0   = 5'd14;
  localparam logic [OP_W-1:0] S_B_C1   = 5'd15;
  localparam logic [OP_W-1:0] S_B_C2   = 5'd16;
  localparam logic [OP_W-1:0] S_E_ACC  = 5'd17;
  localparam logic [OP_W-1:0] S_E_EMIT = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            accept;
  } mpoc_cmd_t;

  typedef struct packed {
    logic built;
    logic tx_skip;
    logic ld_mark;
    logic t_nz;
    logic c_last;
    logic q_empty;
    logic acc_done;
    logic emit_last;
    logic out_free;
    logic clr_done;
  } mpoc_stat_t;

  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic en);
    logic [BYTE_W-1:0] r;
    r = b;
    if (en && b >= 8'd65 && b <= 8'd90) r = b + 8'd32;
    return r;
  endfunction

endpackage

[design/multi_pattern_occurrence_counter.sv]
// Aho-Corasick multi-pattern occurrence counter.
// Input beats (in_valid/in_stall) carry a kind: pattern byte, build, text byte,
// end of document, clear all. One beat is in work at a time; in_stall is low
// only when the controller is idle.
// Steps per beat: a pattern byte reads and evaluates the table, plus a mask
// read and write on a pattern's last byte; a text byte does a table read,
// mask read and counter update; build walks the root's byte values, then
// each trie state in breadth order, its failure link and its byte values;
// end of document first sums the counts of all N loaded patterns.
// It then emits one result beat per pattern (one if none are loaded) on
// out_valid/out_stall. Results sit in an output register, so the next input
// beat can be taken while the last result still waits; a stalled receiver
// holds the emit walk.
// After reset and after a clear-all beat the transition and mask tables are
// swept to zero, MAX_STATES * 256 entries (65536 by default), with in_stall
// high. Configuration writes (cfg_we/cfg_index/cfg_wdata) are taken any time.
module multi_pattern_occurrence_counter #(
  parameter int MAX_STATES   = 256,
  parameter int MAX_PATTERNS = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [mpoc_pkg::KIND_W-1:0]  in_kind,
  input  logic [mpoc_pkg::BYTE_W-1:0]  in_byte_value,
  input  logic                         in_pattern_end,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mpoc_pkg::IDX_W-1:0]   out_pattern_index,
  output logic [mpoc_pkg::OCC_W-1:0]   out_occurrences,
  output logic [mpoc_pkg::SCORE_W-1:0] out_document_score,
  output logic [mpoc_pkg::STAT_W-1:0]  out_status,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic                         cfg_wdata
);
  import mpoc_pkg::*;

  mpoc_cmd_t  cmd;
  mpoc_stat_t stat;

  mpoc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  mpoc_dp #(
    .MAX_STATES   (MAX_STATES),
    .MAX_PATTERNS (MAX_PATTERNS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_kind            (in_kind),
    .in_byte_value      (in_byte_value),
    .in_pattern_end     (in_pattern_end),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pattern_index  (out_pattern_index),
    .out_occurrences    (out_occurrences),
    .out_document_score (out_document_score),
    .out_status         (out_status),
    .out_last           (out_last)
  );

endmodule

[design/mpoc_ctrl.sv]
module mpoc_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [mpoc_pkg::KIND_W-1:0] in_kind,
  output logic                        in_stall,
  input  mpoc_pkg::mpoc_stat_t        stat,
  output mpoc_pkg::mpoc_cmd_t         cmd
);
  import mpoc_pkg::*;

  logic [OP_W-1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (stat.clr_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_valid) begin
          case (in_kind)
            K_LOAD:  state_nxt = stat.built ? S_IDLE : S_LD_RD;
            K_BUILD: state_nxt = stat.built ? S_IDLE : S_B_R0;
            K_TEXT:  state_nxt = (!stat.built || stat.tx_skip) ? S_IDLE : S_TX_RD;
            K_EOD:   state_nxt = S_E_ACC;
            K_CLEAR: state_nxt = S_CLEAR;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_LD_RD:  state_nxt = S_LD_EV;
      S_LD_EV:  state_nxt = stat.ld_mark ? S_LD_MR : S_IDLE;
      S_LD_MR:  state_nxt = S_LD_MW;
      S_LD_MW:  state_nxt = S_IDLE;
      S_TX_RD:  state_nxt = S_TX_MR;
      S_TX_MR:  state_nxt = S_TX_CNT;
      S_TX_CNT: state_nxt = S_IDLE;
      S_B_R0:   state_nxt = S_B_R1;
      S_B_R1:   state_nxt = stat.c_last ? S_B_DEQ : S_B_R0;
      S_B_DEQ:  state_nxt = stat.q_empty ? S_IDLE : S_B_S;
      S_B_S:    state_nxt = S_B_F;
      S_B_F:    state_nxt = S_B_C0;
      S_B_C0:   state_nxt = S_B_C1;
      S_B_C1: begin
        if (stat.t_nz) state_nxt = S_B_C2;
        else state_nxt = stat.c_last ? S_B_DEQ : S_B_C0;
      end
      S_B_C2:   state_nxt = stat.c_last ? S_B_DEQ : S_B_C0;
      S_E_ACC:  state_nxt = stat.acc_done ? S_E_EMIT : S_E_ACC;
      S_E_EMIT: if (stat.out_free && stat.emit_last) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  assign in_stall   = (state_r != S_IDLE);
  assign cmd.op     = state_r;
  assign cmd.accept = (state_r == S_IDLE) && in_valid;

endmodule

[design/mpoc_dp.sv]
module mpoc_dp #(
  parameter int MAX_STATES   = 256,
  parameter int MAX_PATTERNS = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [mpoc_pkg::KIND_W-1:0]    in_kind,
  input  logic [mpoc_pkg::BYTE_W-1:0]    in_byte_value,
  input  logic                           in_pattern_end,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic                           cfg_wdata,
  input  mpoc_pkg::mpoc_cmd_t            cmd,
  output mpoc_pkg::mpoc_stat_t           stat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mpoc_pkg::IDX_W-1:0]     out_pattern_index,
  output logic [mpoc_pkg::OCC_W-1:0]     out_occurrences,
  output logic [mpoc_pkg::SCORE_W-1:0]   out_document_score,
  output logic [mpoc_pkg::STAT_W-1:0]    out_status,
  output logic                           out_last
);
  import mpoc_pkg::*;

  localparam int SW       = $clog2(MAX_STATES);
  localparam int AW       = SW + BYTE_W;
  localparam int TT_DEPTH = MAX_STATES * ALPHA;
  localparam int SUW      = $clog2(MAX_STATES + 1);
  localparam int PUW      = $clog2(MAX_PATTERNS + 1);
  localparam int PIW      = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int SUMW     = ((COUNT_WIDTH > SCORE_W) ? COUNT_WIDTH : SCORE_W) + 1;

  logic                    fold_r, skip_r;
  logic [BYTE_W-1:0]       byte_r;
  logic                    end_r;
  logic [SW-1:0]           cursor_r, scan_r, s_r, f_r, t_r, head_r, tail_r;
  logic [BYTE_W-1:0]       c_r;
  logic [SUW-1:0]          su_r;
  logic [PUW-1:0]          pu_r, p_r;
  logic                    built_r, ovf_r, disc_r;
  logic [AW-1:0]           sweep_r;
  logic [SCORE_W-1:0]      acc_r, score_r;
  logic                    absent_r;
  logic [COUNT_WIDTH-1:0]  cnt_r [MAX_PATTERNS];

  logic                    out_valid_r, out_last_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic [OCC_W-1:0]        out_occ_r;
  logic [SCORE_W-1:0]      out_score_r;
  logic [STAT_W-1:0]       out_status_r;

  // memories
  logic [SW-1:0]           tt_mem [TT_DEPTH];
  logic [SW-1:0]           ra_r, rb_r;
  logic [MAX_PATTERNS-1:0] mm_mem [MAX_STATES];
  logic [MAX_PATTERNS-1:0] ma_r, mb_r;
  logic [SW-1:0]           fl_mem [MAX_STATES];
  logic [SW-1:0]           fl_rd_r;
  logic [SW-1:0]           q_mem [MAX_STATES];
  logic [SW-1:0]           qd_r;

  logic [BYTE_W-1:0]       fold_b;
  logic [AW-1:0]           addr_a, addr_b, tt_wa;
  logic                    tt_we;
  logic [SW-1:0]           tt_wd;
  logic [SW-1:0]           mm_ra, mm_wa;
  logic                    mm_we;
  logic [MAX_PATTERNS-1:0] mm_wd;
  logic                    bq_we;
  logic [SW-1:0]           fl_wd;
  logic                    pat_full, st_full, ld_new, ld_drop, ld_mark;
  logic [SW-1:0]           ld_next;
  logic [SUMW-1:0]         sum;
  logic [COUNT_WIDTH-1:0]  cnt_p;
  logic                    out_free, emit_last;

  assign fold_b  = fold_byte(byte_r, fold_r);
  assign addr_b  = {f_r, c_r};
  assign cnt_p   = cnt_r[p_r[PIW-1:0]];

  always_comb begin
    case (cmd.op)
      S_TX_RD: addr_a = {scan_r, fold_b};
      S_B_R0:  addr_a = {{SW{1'b0}}, c_r};
      S_B_C0:  addr_a = {s_r, c_r};
      default: addr_a = {cursor_r, fold_b};
    endcase
  end

  // pattern byte evaluation
  assign pat_full = pu_r >= PUW'(MAX_PATTERNS);
  assign st_full  = su_r >= SUW'(MAX_STATES);
  assign ld_new   = !disc_r && !pat_full && (ra_r == '0) && !st_full;
  assign ld_drop  = !disc_r && (pat_full || ((ra_r == '0) && st_full));
  assign ld_next  = (ra_r == '0) ? su_r[SW-1:0] : ra_r;
  assign ld_mark  = end_r && !disc_r && !ld_drop;

  always_comb begin
    tt_we = 1'b0;
    tt_wa = addr_a;
    tt_wd = su_r[SW-1:0];
    case (cmd.op)
      S_CLEAR: begin
        tt_we = 1'b1;
        tt_wa = sweep_r;
        tt_wd = '0;
      end
      S_LD_EV: tt_we = ld_new;
      S_B_C1: begin
        tt_we = (ra_r == '0);
        tt_wa = {s_r, c_r};
        tt_wd = rb_r;
      end
      default: tt_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (tt_we) tt_mem[tt_wa] <= tt_wd;
    ra_r <= tt_mem[addr_a];
    rb_r <= tt_mem[addr_b];
  end

  always_comb begin
    mm_ra = (cmd.op == S_LD_MR) ? cursor_r : ra_r;
    mm_we = 1'b0;
    mm_wa = t_r;
    mm_wd = ma_r | mb_r;
    case (cmd.op)
      S_CLEAR: begin
        mm_we = (sweep_r[BYTE_W-1:0] == '0);
        mm_wa = sweep_r[AW-1:BYTE_W];
        mm_wd = '0;
      end
      S_LD_MW: begin
        mm_we = 1'b1;
        mm_wa = cursor_r;
        mm_wd = ma_r | (MAX_PATTERNS'(1) << pu_r);
      end
      S_B_C2:  mm_we = 1'b1;
      default: mm_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mm_we) mm_mem[mm_wa] <= mm_wd;
    ma_r <= mm_mem[mm_ra];
    mb_r <= mm_mem[rb_r];
  end

  // failure links and breadth queue share the enqueue strobe
  assign bq_we = ((cmd.op == S_B_R1) || (cmd.op == S_B_C1)) && (ra_r != '0);
  assign fl_wd = (cmd.op == S_B_C1) ? rb_r : '0;

  always_ff @(posedge clk) begin
    if (bq_we) begin
      fl_mem[ra_r]  <= fl_wd;
      q_mem[tail_r] <= ra_r;
    end
    qd_r    <= q_mem[head_r];
    fl_rd_r <= fl_mem[qd_r];
  end

  assign sum       = SUMW'(acc_r) + SUMW'(cnt_p);
  assign out_free  = !out_valid_r || !out_stall;
  assign emit_last = (pu_r == '0) || ((p_r + PUW'(1)) == pu_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_r      <= 1'b1;
      skip_r      <= 1'b1;
      out_valid_r <= 1'b0;
      su_r        <= SUW'(1);
      pu_r        <= '0;
      cursor_r    <= '0;
      scan_r      <= '0;
      built_r     <= 1'b0;
      ovf_r       <= 1'b0;
      disc_r      <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      c_r         <= '0;
      sweep_r     <= '0;
      p_r         <= '0;
      for (int i = 0; i < MAX_PATTERNS; i++) cnt_r[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FOLD_CASE: fold_r <= cfg_wdata;
          REG_SKIP_HIGH: skip_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      if (cmd.accept) begin
        byte_r <= in_byte_value;
        end_r  <= in_pattern_end;
        if (in_kind == K_CLEAR) begin
          su_r     <= SUW'(1);
          pu_r     <= '0;
          cursor_r <= '0;
          scan_r   <= '0;
          built_r  <= 1'b0;
          ovf_r    <= 1'b0;
          disc_r   <= 1'b0;
          head_r   <= '0;
          tail_r   <= '0;
          c_r      <= '0;
          sweep_r  <= '0;
          for (int i = 0; i < MAX_PATTERNS; i++) cnt_r[i] <= '0;
        end
        if (in_kind == K_EOD) begin
          p_r      <= '0;
          acc_r    <= '0;
          absent_r <= 1'b0;
        end
      end

      case (cmd.op)
        S_CLEAR: sweep_r <= sweep_r + AW'(1);
        S_LD_EV: begin
          if (ld_drop) ovf_r <= 1'b1;
          if (!disc_r && !ld_drop) cursor_r <= ld_next;
          if (ld_new) su_r <= su_r + SUW'(1);
          if (end_r) begin
            if (!ld_mark) begin
              cursor_r <= '0;
              disc_r   <= 1'b0;
            end
          end else begin
            disc_r <= disc_r | ld_drop;
          end
        end
        S_LD_MW: begin
          pu_r     <= pu_r + PUW'(1);
          cursor_r <= '0;
          disc_r   <= 1'b0;
        end
        S_TX_MR: scan_r <= ra_r;
        S_TX_CNT: begin
          for (int i = 0; i < MAX_PATTERNS; i++)
            if (ma_r[i] && cnt_r[i] != {COUNT_WIDTH{1'b1}}) cnt_r[i] <= cnt_r[i] + 1'b1;
        end
        S_B_R1: begin
          if (ra_r != '0) tail_r <= tail_r + SW'(1);
          c_r <= c_r + 8'd1;
        end
        S_B_DEQ: begin
          if (head_r == tail_r) begin
            built_r  <= 1'b1;
            cursor_r <= '0;
            scan_r   <= '0;
          end
        end
        S_B_S: begin
          s_r    <= qd_r;
          head_r <= head_r + SW'(1);
        end
        S_B_F: f_r <= fl_rd_r;
        S_B_C1: begin
          if (ra_r != '0) begin
            tail_r <= tail_r + SW'(1);
            t_r    <= ra_r;
          end else begin
            c_r <= c_r + 8'd1;
          end
        end
        S_B_C2: c_r <= c_r + 8'd1;
        S_E_ACC: begin
          if (p_r == pu_r) begin
            score_r <= (absent_r || pu_r == '0) ? '0 : acc_r;
            p_r     <= '0;
          end else begin
            acc_r    <= (sum > SUMW'(SCORE_MAX)) ? SCORE_MAX : sum[SCORE_W-1:0];
            absent_r <= absent_r | (cnt_p == '0);
            p_r      <= p_r + PUW'(1);
          end
        end
        S_E_EMIT: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_idx_r    <= IDX_W'(p_r);
            out_occ_r    <= OCC_W'(cnt_p);
            out_score_r  <= score_r;
            out_status_r <= ovf_r ? ST_OVF : (built_r ? ST_OK : ST_NOT_BUILT);
            out_last_r   <= emit_last;
            p_r          <= p_r + PUW'(1);
            if (emit_last) begin
              scan_r <= '0;
              for (int i = 0; i < MAX_PATTERNS; i++) cnt_r[i] <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign stat.built     = built_r;
  assign stat.tx_skip   = skip_r && in_byte_value[BYTE_W-1];
  assign stat.ld_mark   = ld_mark;
  assign stat.t_nz      = (ra_r != '0);
  assign stat.c_last    = (c_r == {BYTE_W{1'b1}});
  assign stat.q_empty   = (head_r == tail_r);
  assign stat.acc_done  = (p_r == pu_r);
  assign stat.emit_last = emit_last;
  assign stat.out_free  = out_free;
  assign stat.clr_done  = (sweep_r == AW'(TT_DEPTH - 1));

  assign out_valid          = out_valid_r;
  assign out_pattern_index  = out_idx_r;
  assign out_occurrences    = out_occ_r;
  assign out_document_score = out_score_r;
  assign out_status         = out_status_r;
  assign out_last           = out_last_r;

  a_states_bound: assert property (@(posedge clk) disable iff (!rst_n)
    su_r <= SUW'(MAX_STATES)) else $error("state count beyond table");
  a_patterns_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pu_r <= PUW'(MAX_PATTERNS)) else $error("pattern count beyond table");
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r) else $error("queue head passed tail");
  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == S_E_EMIT && out_free && emit_last) |=> (scan_r == '0))
    else $error("scan state not reset after document end");

endmodule
